@@ sv/udf_pkg.sv @@
// Shared constants, types and the front-to-back descriptor for the decimal field formatter.
`default_nettype none

package udf_pkg;

    localparam int VALUE_W = 32;
    localparam int DIGITS = 10;
    localparam int DIG_W = 4;
    localparam int DSEL_W = $clog2(DIGITS);
    localparam int LEN_W = 6;
    localparam int CH_W = 8;
    localparam int CNT_W = $clog2(VALUE_W);
    localparam int PREC_W = 7;

    localparam logic [LEN_W-1:0] MAX_FIELD = 6'd63;

    localparam logic [CH_W-1:0] CH_ZERO = 8'h30;
    localparam logic [CH_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CH_W-1:0] CH_NONE = 8'h00;

    localparam int FIFO_DEPTH = 2;
    localparam int FIFO_PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    typedef logic [DIGITS-1:0][DIG_W-1:0] bcd_t;

    // One formatted field, ready for character emission
    typedef struct packed {
        bcd_t             bcd;
        logic [DIG_W-1:0] digits;
        logic [LEN_W-1:0] lead_end;
        logic [LEN_W-1:0] zero_end;
        logic [LEN_W-1:0] dig_end;
        logic [LEN_W-1:0] last_idx;
        logic [LEN_W-1:0] total;
        logic             lead_zero;
        logic             empty;
    } desc_t;

endpackage

`default_nettype wire

@@ sv/udf_fifo.sv @@
// Short descriptor queue between the conversion front and the character back end.
`default_nettype none

module udf_fifo
    import udf_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  push,
    input  wire desc_t push_data,
    output logic       full,
    input  wire logic  pop,
    output logic       head_valid,
    output desc_t      head
);

    desc_t                 mem_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg;
    logic [FIFO_PTR_W-1:0] wr_ptr_next;
    logic [FIFO_PTR_W-1:0] rd_ptr_reg;
    logic [FIFO_PTR_W-1:0] rd_ptr_next;
    logic [FIFO_CNT_W-1:0] count_reg;
    logic [FIFO_CNT_W-1:0] count_next;
    logic                  do_push;
    logic                  do_pop;

    assign full       = (count_reg == FIFO_CNT_W'(FIFO_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = mem_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0
                                                                       : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0
                                                                       : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FIFO_CNT_W'(FIFO_DEPTH))
        else $error("queue count above depth");

    a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (do_push && !do_pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("push did not grow the queue");

endmodule

`default_nettype wire

@@ sv/udf_front.sv @@
// Front end: takes an item, converts the value to BCD one bit a cycle and builds the field layout.
`default_nettype none

module udf_front
    import udf_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic [VALUE_W-1:0] value,
    input  wire logic [LEN_W-1:0]   field_width,
    input  wire logic signed [PREC_W-1:0] precision,
    input  wire logic               left_align,
    input  wire logic               zero_pad,
    output logic                    push,
    output desc_t                   push_data,
    input  wire logic               full
);

    typedef enum logic [3:0] {
        F_IDLE  = 4'b0001,
        F_CONV  = 4'b0010,
        F_CLASS = 4'b0100,
        F_PUSH  = 4'b1000
    } front_state_t;

    front_state_t        state_reg;
    front_state_t        state_next;
    logic [CNT_W-1:0]    cnt_reg;
    logic [CNT_W-1:0]    cnt_next;
    logic [VALUE_W-1:0]  sh_reg;
    logic [VALUE_W-1:0]  sh_next;
    bcd_t                bcd_reg;
    bcd_t                bcd_next;
    logic [LEN_W-1:0]    width_reg;
    logic [PREC_W-1:0]   prec_reg;
    logic                left_reg;
    logic                zflag_reg;
    logic [DIG_W-1:0]    digits_reg;
    logic [DIG_W-1:0]    digits_next;

    bcd_t                       bcd_adj;
    logic [DIGITS*DIG_W-1:0]    bcd_flat;
    logic                has_prec;
    logic [LEN_W-1:0]    prec_eff;
    logic [LEN_W-1:0]    width_eff;
    logic [LEN_W-1:0]    digits_ext;
    logic [LEN_W-1:0]    zero_fill;
    logic [LEN_W-1:0]    len;
    logic [LEN_W-1:0]    total;
    logic [LEN_W-1:0]    pad;
    logic [LEN_W-1:0]    lead_end;
    logic [LEN_W-1:0]    zero_end;
    logic [DIG_W-1:0]    nz_count;

    assign in_stall = (state_reg != F_IDLE);

    // double dabble: add 3 to each digit of 5 or more, then shift in the next bit
    always_comb
    begin
        for (int j = 0; j < DIGITS; j++)
        begin
            bcd_adj[j] = (bcd_reg[j] >= DIG_W'(5)) ? bcd_reg[j] + DIG_W'(3) : bcd_reg[j];
        end
    end

    assign bcd_flat = bcd_adj;

    assign has_prec  = !prec_reg[PREC_W-1];
    assign prec_eff  = (prec_reg[LEN_W-1:0] > MAX_FIELD) ? MAX_FIELD : prec_reg[LEN_W-1:0];
    assign width_eff = (width_reg > MAX_FIELD) ? MAX_FIELD : width_reg;

    always_comb
    begin
        nz_count = DIG_W'(1);
        for (int j = 0; j < DIGITS; j++)
        begin
            if (bcd_reg[j] != '0)
            begin
                nz_count = DIG_W'(j + 1);
            end
        end
    end

    // field layout from the digit count
    assign digits_ext = LEN_W'(digits_reg);
    assign zero_fill  = (has_prec && (prec_eff > digits_ext)) ? prec_eff - digits_ext : '0;
    assign len        = digits_ext + zero_fill;
    assign total      = (width_eff > len) ? width_eff : len;
    assign pad        = (width_eff > len) ? width_eff - len : '0;
    assign lead_end   = left_reg ? '0 : pad;
    assign zero_end   = lead_end + zero_fill;

    always_comb
    begin
        push_data.bcd       = bcd_reg;
        push_data.digits    = digits_reg;
        push_data.lead_end  = lead_end;
        push_data.zero_end  = zero_end;
        push_data.dig_end   = zero_end + digits_ext;
        push_data.last_idx  = total - 1'b1;
        push_data.total     = total;
        push_data.lead_zero = zflag_reg && !left_reg && !has_prec;
        push_data.empty     = (total == '0);
    end

    assign push = (state_reg == F_PUSH);

    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        sh_next     = sh_reg;
        bcd_next    = bcd_reg;
        digits_next = digits_reg;
        case (state_reg)
            F_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = F_CONV;
                    cnt_next   = '0;
                    sh_next    = value;
                    bcd_next   = '0;
                end
            end
            F_CONV:
            begin
                bcd_next = {bcd_flat[DIGITS*DIG_W-2:0], sh_reg[VALUE_W-1]};
                sh_next  = {sh_reg[VALUE_W-2:0], 1'b0};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(VALUE_W - 1))
                begin
                    state_next = F_CLASS;
                end
            end
            F_CLASS:
            begin
                // zero value with zero precision prints no digits
                if ((bcd_reg == '0) && has_prec && (prec_eff == '0))
                begin
                    digits_next = '0;
                end
                else
                begin
                    digits_next = nz_count;
                end
                state_next = F_PUSH;
            end
            F_PUSH:
            begin
                if (!full)
                begin
                    state_next = F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg    <= cnt_next;
        sh_reg     <= sh_next;
        bcd_reg    <= bcd_next;
        digits_reg <= digits_next;
        if ((state_reg == F_IDLE) && in_valid)
        begin
            width_reg <= field_width;
            prec_reg  <= precision;
            left_reg  <= left_align;
            zflag_reg <= zero_pad;
        end
    end

    a_conv_exit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == F_CONV) |=> (state_reg == F_CONV) || (state_reg == F_CLASS))
        else $error("conversion left early");

endmodule

`default_nettype wire

@@ sv/udf_back.sv @@
// Back end: queued field to output register, one character a cycle unless stalled.
`default_nettype none

module udf_back
    import udf_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         head_valid,
    input  wire desc_t        head,
    output logic              pop,
    output logic              out_valid,
    input  wire logic         out_stall,
    output logic [CH_W-1:0]   ch,
    output logic              last,
    output logic              empty_res,
    output logic [LEN_W-1:0]  total_len
);

    logic [LEN_W-1:0]  pos_reg;
    logic [LEN_W-1:0]  pos_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [CH_W-1:0]   ch_reg;
    logic              last_reg;
    logic              empty_reg;
    logic [LEN_W-1:0]  total_reg;

    logic              load_ok;
    logic              emit;
    logic              is_last;
    logic [LEN_W-1:0]  k;
    logic [DSEL_W-1:0] dsel;
    logic [CH_W-1:0]   ch_sel;

    assign load_ok = !out_valid_reg || !out_stall;
    assign emit    = head_valid && load_ok;
    assign is_last = head.empty || (pos_reg == head.last_idx);
    assign pop     = emit && is_last;

    assign k    = pos_reg - head.zero_end;
    assign dsel = DSEL_W'(head.digits - DIG_W'(1) - k[DIG_W-1:0]);

    always_comb
    begin
        if (head.empty)
        begin
            ch_sel = CH_NONE;
        end
        else if (pos_reg < head.lead_end)
        begin
            ch_sel = head.lead_zero ? CH_ZERO : CH_SPACE;
        end
        else if (pos_reg < head.zero_end)
        begin
            ch_sel = CH_ZERO;
        end
        else if (pos_reg < head.dig_end)
        begin
            ch_sel = CH_ZERO + CH_W'(head.bcd[dsel]);
        end
        else
        begin
            ch_sel = CH_SPACE;
        end
    end

    always_comb
    begin
        pos_next       = pos_reg;
        out_valid_next = out_valid_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
            pos_next       = is_last ? '0 : pos_reg + 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg       <= pos_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            ch_reg    <= ch_sel;
            last_reg  <= is_last;
            empty_reg <= head.empty;
            total_reg <= head.total;
        end
    end

    assign out_valid = out_valid_reg;
    assign ch        = ch_reg;
    assign last      = last_reg;
    assign empty_res = empty_reg;
    assign total_len = total_reg;

    a_pos_in_field: assert property (@(posedge clk) disable iff (!rst_n)
        (head_valid && !head.empty) |-> (pos_reg <= head.last_idx))
        else $error("character index past end of field");

    a_pop_resets_pos: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> (pos_reg == '0))
        else $error("index not cleared after last character");

endmodule

`default_nettype wire

@@ sv/unsigned_decimal_field_formatter_top.sv @@
// Top level of the unsigned decimal field formatter.
// Formats a 32-bit unsigned value as printf %u text, one ASCII character per output item,
// with last on the final character and total_len on every one; an empty field gives one item
// with empty_res set. The front end takes an input item, converts it by bit-serial
// binary-to-BCD conversion, counts its digits and queues the field layout, waiting while
// the queue is full; only then does it take the next item. The back end sends one character
// per cycle, unless the receiver stalls, from a two-entry queue: total_len characters per
// field, and one item for an empty field.
`default_nettype none

module unsigned_decimal_field_formatter_top
    import udf_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     in_valid,
    output logic                          in_stall,
    input  wire logic [VALUE_W-1:0]       value,
    input  wire logic [LEN_W-1:0]         field_width,
    input  wire logic signed [PREC_W-1:0] precision,
    input  wire logic                     left_align,
    input  wire logic                     zero_pad,
    output logic                          out_valid,
    input  wire logic                     out_stall,
    output logic [CH_W-1:0]               ch,
    output logic                          last,
    output logic                          empty_res,
    output logic [LEN_W-1:0]              total_len
);

    logic  push;
    desc_t push_data;
    logic  full;
    logic  pop;
    logic  head_valid;
    desc_t head;

    udf_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .value       (value),
        .field_width (field_width),
        .precision   (precision),
        .left_align  (left_align),
        .zero_pad    (zero_pad),
        .push        (push),
        .push_data   (push_data),
        .full        (full)
    );

    udf_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_data  (push_data),
        .full       (full),
        .pop        (pop),
        .head_valid (head_valid),
        .head       (head)
    );

    udf_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .ch         (ch),
        .last       (last),
        .empty_res  (empty_res),
        .total_len  (total_len)
    );

endmodule

`default_nettype wire

@@ sim/tb_unsigned_decimal_field_formatter_top.sv @@
// Testbench for the unsigned decimal field formatter: directed table plus random fields.
`timescale 1ns / 100ps

module tb_unsigned_decimal_field_formatter_top
    import udf_pkg::*;
();

    localparam int RANDOM_ITEMS = 460;
    localparam int IDLE_PCT = 21;
    localparam int CALM_FROM = 300;
    localparam int CALM_TO = 380;
    localparam int PAUSE_AT = 170;
    localparam int DRAIN_CYCLES = 150;
    localparam int CYCLE_LIMIT = 1000000;

    typedef struct packed {
        logic [CH_W-1:0]  ch;
        logic             last;
        logic             empty;
        logic [LEN_W-1:0] len;
    } field_char_t;

    typedef struct {
        logic [VALUE_W-1:0]       value;
        logic [LEN_W-1:0]         width;
        logic signed [PREC_W-1:0] prec;
        bit                       left;
        bit                       zpad;
        bit                       typed;
        string                    txt;
    } stim_row_t;

    logic                     clk;
    logic                     rst_n;
    logic                     in_valid;
    logic                     in_stall;
    logic [VALUE_W-1:0]       value;
    logic [LEN_W-1:0]         field_width;
    logic signed [PREC_W-1:0] precision;
    logic                     left_align;
    logic                     zero_pad;
    logic                     out_valid;
    logic                     out_stall;
    logic [CH_W-1:0]          ch;
    logic                     last;
    logic                     empty_res;
    logic [LEN_W-1:0]         total_len;

    field_char_t pending_chars[$];
    stim_row_t   dir_rows[$];
    int          mismatches = 0;
    int          cycles = 0;
    bit          steady = 1'b0;

    unsigned_decimal_field_formatter_top u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .value       (value),
        .field_width (field_width),
        .precision   (precision),
        .left_align  (left_align),
        .zero_pad    (zero_pad),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .ch          (ch),
        .last        (last),
        .empty_res   (empty_res),
        .total_len   (total_len)
    );

    initial clk = 1'b0;
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d chars pending", cycles,
                     pending_chars.size());
            $display("** unsigned_decimal_field_formatter_top: FAILED **");
            $finish;
        end
    end

    task automatic note_mismatch(input string what, input longint got, input longint want);
        mismatches++;
        $display("cycle %0d: %s got %0d expected %0d", cycles, what, got, want);
    endtask

    // Expected characters of one %u conversion
    function automatic void format_field(input logic [VALUE_W-1:0] v,
                                         input logic [LEN_W-1:0] w,
                                         input logic signed [PREC_W-1:0] p,
                                         input bit la, input bit zp);
        logic [CH_W-1:0]    text[$];
        logic [CH_W-1:0]    digs[$];
        logic [CH_W-1:0]    lead;
        logic [VALUE_W-1:0] t;
        bit                 has_prec;
        int                 prec_n, ndig, zfill, body, tot, pad, wi;

        has_prec = !p[PREC_W-1];
        prec_n = has_prec ? int'(p[PREC_W-2:0]) : -1;
        wi = int'(w);
        ndig = 1;
        t = v;
        while (t >= 10)
        begin
            t = t / 10;
            ndig++;
        end
        if (has_prec && prec_n == 0 && v == 0)
            ndig = 0;
        zfill = (prec_n > ndig) ? prec_n - ndig : 0;
        body = ndig + zfill;
        tot = (wi > body) ? wi : body;
        if (tot > int'(MAX_FIELD))
            tot = int'(MAX_FIELD);
        if (tot == 0)
        begin
            pending_chars.push_back('{CH_NONE, 1'b1, 1'b1, '0});
            return;
        end
        pad = (wi > body) ? wi - body : 0;
        lead = (zp && !la && !has_prec) ? CH_ZERO : CH_SPACE;
        if (!la)
            repeat (pad) text.push_back(lead);
        repeat (zfill) text.push_back(CH_ZERO);
        t = v;
        repeat (ndig)
        begin
            digs.push_front(CH_ZERO + CH_W'(t % 10));
            t = t / 10;
        end
        foreach (digs[i])
            text.push_back(digs[i]);
        if (la)
            repeat (pad) text.push_back(CH_SPACE);
        foreach (text[i])
            pending_chars.push_back('{text[i], i == text.size() - 1, 1'b0, LEN_W'(tot)});
    endfunction

    task automatic add_row(input logic [VALUE_W-1:0] v, input int w, input int p,
                           input bit la, input bit zp, input bit typed, input string txt);
        stim_row_t r;
        r.value = v;
        r.width = LEN_W'(w);
        r.prec = PREC_W'(p);
        r.left = la;
        r.zpad = zp;
        r.typed = typed;
        r.txt = txt;
        dir_rows.push_back(r);
    endtask

    // Result checker
    always @(posedge clk)
    begin
        field_char_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_chars.size() == 0)
                note_mismatch("char with nothing pending, ch", ch, 0);
            else
            begin
                want = pending_chars.pop_front();
                if (ch !== want.ch)
                    note_mismatch("ch", ch, want.ch);
                if (last !== want.last)
                    note_mismatch("last", last, want.last);
                if (empty_res !== want.empty)
                    note_mismatch("empty_res", empty_res, want.empty);
                if (total_len !== want.len)
                    note_mismatch("total_len", total_len, want.len);
            end
        end
    end

    // Receiver stalls
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            out_stall = !steady && ($urandom_range(99) < IDLE_PCT);
        end
    end

    initial
    begin
        stim_row_t          row;
        logic [VALUE_W-1:0] p10;
        int                 n, total_items, sel;

        rst_n = 1'b0;
        in_valid = 1'b0;
        value = '0;
        field_width = '0;
        precision = '0;
        left_align = 1'b0;
        zero_pad = 1'b0;

        //        value          w    p   la zp typed text
        add_row(32'd0,          0,   0,  0, 0, 1, "");
        add_row(32'd0,          0,  -1,  0, 0, 1, "0");
        add_row(32'hFFFF_FFFF,  0,  -1,  0, 0, 1, "4294967295");
        add_row(32'd42,         5,  -1,  0, 1, 1, "00042");
        add_row(32'd42,         5,  -1,  1, 0, 1, "42   ");
        add_row(32'd42,         5,   3,  0, 1, 1, "  042");
        add_row(32'd7,          0, -64,  0, 0, 1, "7");
        add_row(32'd0,          3,   0,  0, 0, 1, "   ");
        add_row(32'd123,        6,  -1,  1, 1, 1, "123   ");
        add_row(32'd0,          0,  -1,  0, 1, 1, "0");
        add_row(32'd5,          3, -17,  0, 1, 1, "005");
        add_row(32'd0,          5,   0,  1, 0, 1, "     ");
        add_row(32'd999999999, 10,  10,  0, 0, 1, "0999999999");
        add_row(32'd10,         1,   1,  0, 0, 1, "10");
        add_row(32'd1,          0,   1,  0, 0, 1, "1");
        add_row(32'd0,          2,  -2,  0, 1, 1, "00");
        add_row(32'hFFFF_FFFF, 63,  -1,  0, 1, 0, "");
        add_row(32'hFFFF_FFFF,  0,  63,  0, 0, 0, "");
        add_row(32'd9,         63,  63,  1, 1, 0, "");
        add_row(32'd1000000000, 12, -1,  1, 0, 0, "");
        add_row(32'd0,         63,   0,  0, 1, 0, "");
        add_row(32'd4000000000, 63, 20,  1, 0, 0, "");

        total_items = dir_rows.size() + RANDOM_ITEMS;
        repeat (2) @(negedge clk);
        rst_n = 1'b1;

        for (n = 0; n < total_items; n++)
        begin
            @(negedge clk);
            // hold off until the block has drained everything
            if (n == dir_rows.size() || n == PAUSE_AT)
            begin
                in_valid = 1'b0;
                while (pending_chars.size() != 0)
                    @(negedge clk);
                @(negedge clk);
            end
            steady = (n >= CALM_FROM && n < CALM_TO);
            while (!steady && $urandom_range(99) < IDLE_PCT)
            begin
                in_valid = 1'b0;
                @(negedge clk);
            end

            if (n < dir_rows.size())
                row = dir_rows[n];
            else
            begin
                sel = $urandom_range(9);
                if (sel <= 2)
                    row.value = $urandom;
                else if (sel <= 4)
                    row.value = $urandom_range(99);
                else if (sel <= 6)
                begin
                    // around a power of ten
                    p10 = 1;
                    repeat ($urandom_range(9)) p10 = p10 * 10;
                    row.value = p10 - $urandom_range(1);
                end
                else if (sel == 7)
                    row.value = '0;
                else if (sel == 8)
                    row.value = $urandom >> $urandom_range(31);
                else
                    row.value = 32'hFFFF_FFFF - $urandom_range(3);

                row.width = ($urandom_range(99) < 80) ? LEN_W'($urandom_range(16))
                                                      : LEN_W'($urandom_range(17, 63));
                sel = $urandom_range(99);
                if (sel < 35)
                    row.prec = PREC_W'($urandom_range(64, 127));
                else if (sel < 50)
                    row.prec = '0;
                else if (sel < 90)
                    row.prec = PREC_W'($urandom_range(1, 15));
                else
                    row.prec = PREC_W'($urandom_range(16, 63));
                row.left = $urandom_range(1);
                row.zpad = $urandom_range(1);
                row.typed = 1'b0;
            end

            value = row.value;
            field_width = row.width;
            precision = row.prec;
            left_align = row.left;
            zero_pad = row.zpad;
            in_valid = 1'b1;
            do
                @(posedge clk);
            while (in_stall);

            if (!row.typed)
                format_field(row.value, row.width, row.prec, row.left, row.zpad);
            else if (row.txt.len() == 0)
                pending_chars.push_back('{CH_NONE, 1'b1, 1'b1, '0});
            else
                for (int i = 0; i < row.txt.len(); i++)
                    pending_chars.push_back('{row.txt[i], i == row.txt.len() - 1, 1'b0,
                                              LEN_W'(row.txt.len())});
        end

        @(negedge clk);
        in_valid = 1'b0;
        steady = 1'b0;
        while (pending_chars.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (mismatches == 0)
            $display("** unsigned_decimal_field_formatter_top: PASSED **");
        else
            $display("** unsigned_decimal_field_formatter_top: FAILED **");
        $finish;
    end

endmodule
